### hw/rtl/size_class_free_list_pool_core_assert.svh
// Assertion macros for the size-class free-list pool.
// Used by the checker module; no other dependencies.
`ifndef SIZE_CLASS_FREE_LIST_POOL_CORE_ASSERT_SVH
`define SIZE_CLASS_FREE_LIST_POOL_CORE_ASSERT_SVH

// Checked on the rising clock edge, suppressed while reset is asserted.
`define SCFLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on the rising clock edge, also during reset.
`define SCFLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hw/rtl/scflp_pkg.sv
// Shared types, constants and helper functions for the size-class free-list pool.
// No dependencies.
package scflp_pkg;

  localparam int unsigned NUM_CLASSES = 6;
  localparam int unsigned CLASS_DEPTH = 512;
  localparam int unsigned ADDR_BITS   = 48;

  localparam int unsigned MEM_DEPTH = NUM_CLASSES * CLASS_DEPTH;
  localparam int unsigned MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned FILL_W    = $clog2(CLASS_DEPTH + 1);
  localparam int unsigned CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  localparam int unsigned LIMIT_W     = 10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd512;

  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned OADDR_W = 48;
  localparam int unsigned TOTAL_W = 64;

  localparam logic [2:0] NO_CLASS = 3'd6;
  localparam logic [SIZE_W-1:0] CLASS_SIZE [6] = '{
    32'd32, 32'd128, 32'd256, 32'd512, 32'd2048, 32'd4096
  };

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    OC_POOL     = 2'd0,
    OC_BACKING  = 2'd1,
    OC_KEPT     = 2'd2,
    OC_RELEASED = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    func_e               func;
    logic [SIZE_W-1:0]   request_size;
    logic [OADDR_W-1:0]  block_address;
  } req_t;

  typedef struct packed {
    outcome_e                  outcome;
    logic [SIZE_W-1:0]         rounded_size;
    logic [OADDR_W-1:0]        granted_address;
    logic signed [TOTAL_W-1:0] backing_bytes;
  } rsp_t;

  // Smallest class holding size, NO_CLASS above the largest class.
  function automatic logic [2:0] size_class(input logic [SIZE_W-1:0] size);
    logic [2:0] cls;
    cls = NO_CLASS;
    for (int i = 5; i >= 0; i--) begin
      if (size <= CLASS_SIZE[i]) begin
        cls = 3'(i);
      end
    end
    return cls;
  endfunction

  function automatic logic [SIZE_W-1:0] round_size(input logic [SIZE_W-1:0] size);
    logic [2:0] cls;
    cls = size_class(size);
    if (cls == NO_CLASS) begin
      return size;
    end
    return CLASS_SIZE[cls];
  endfunction

endpackage

### hw/rtl/size_class_free_list_pool_core.sv
// Size-class free-list pool: one RAM holds a stack of cached block addresses per class.
// Depends on scflp_pkg and scflp_ram.
//
// Usage:
//   Requests arrive on in_valid_i/in_ready_o with an in_req_i payload (allocate or
//   free, byte size, block address). Each request gives exactly one response on
//   out_valid_o/out_ready_i: outcome, rounded size, granted address and the
//   backing-byte total after the request.
//   The class limit is written on cfg_valid_i/cfg_data_i; cfg_ready_o is always
//   high, and writes are expected only while no request is in flight.
//   One request is in flight at a time. A pool allocation reads the stack top from
//   the RAM through its registered read port, so it passes the read state before
//   the response state; every other request goes from acceptance straight to the
//   response state. The next request is taken the cycle after the response is taken.
//   The block cannot take a new request before the last one has been answered; the
//   RAM read port sets the extra read state for a pool hit.
//   A stalled response holds until taken; in_ready_o stays low meanwhile.
//   Reset empties all class stacks (fill counts only), clears the backing total
//   and sets the limit to 512. The RAM itself needs no clearing.
module size_class_free_list_pool_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [scflp_pkg::LIMIT_W-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  scflp_pkg::req_t                     in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output scflp_pkg::rsp_t                     out_rsp_o
);

  scflp_pkg::state_e                     state_q, state_d;
  logic [scflp_pkg::LIMIT_W-1:0]         limit_q;
  logic [scflp_pkg::FILL_W-1:0]          fill_q [scflp_pkg::NUM_CLASSES];
  logic [scflp_pkg::FILL_W-1:0]          fill_d [scflp_pkg::NUM_CLASSES];
  logic signed [scflp_pkg::TOTAL_W-1:0]  total_q, total_d;
  scflp_pkg::rsp_t                       rsp_q, rsp_d;

  logic [2:0]                            cls;
  logic                                  has_class;
  logic [scflp_pkg::CLS_W-1:0]           cls_sel;
  logic [scflp_pkg::FILL_W-1:0]          fill_cur;
  logic [scflp_pkg::FILL_W-1:0]          pos;
  logic                                  can_pop, can_push, is_free, accept;
  logic [scflp_pkg::SIZE_W-1:0]          rounded;
  logic                                  ram_en, ram_we;
  logic [scflp_pkg::MEM_AW-1:0]          ram_addr;
  logic [scflp_pkg::ADDR_BITS-1:0]       ram_wdata, ram_rdata;
  logic [63:0]                           addr_in_wide, addr_out_wide;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == scflp_pkg::ST_IDLE);
  assign out_valid_o = (state_q == scflp_pkg::ST_RESP);
  assign out_rsp_o   = rsp_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cls       = scflp_pkg::size_class(in_req_i.request_size);
    rounded   = scflp_pkg::round_size(in_req_i.request_size);
    // class codes at or above the configured class count have no stack
    has_class = (cls != scflp_pkg::NO_CLASS) && (32'(cls) < scflp_pkg::NUM_CLASSES);
    cls_sel   = scflp_pkg::CLS_W'(cls);
    fill_cur  = has_class ? fill_q[cls_sel] : '0;
    is_free   = (in_req_i.func == scflp_pkg::FUNC_FREE);
    can_pop   = has_class && (fill_cur != '0);
    can_push  = has_class && (32'(fill_cur) < 32'(limit_q))
                && (32'(fill_cur) < scflp_pkg::CLASS_DEPTH);
    pos       = is_free ? fill_cur : fill_cur - 1'b1;
    ram_addr  = scflp_pkg::MEM_AW'(32'(cls_sel) * scflp_pkg::CLASS_DEPTH + 32'(pos));
    ram_we    = accept && is_free && can_push;
    ram_en    = ram_we || (accept && !is_free && can_pop);
    addr_in_wide = 64'(in_req_i.block_address);
    ram_wdata    = addr_in_wide[scflp_pkg::ADDR_BITS-1:0];
    addr_out_wide = 64'(ram_rdata);
  end

  scflp_ram #(
    .Width(scflp_pkg::ADDR_BITS),
    .Depth(scflp_pkg::MEM_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    total_d = total_q;
    rsp_d   = rsp_q;
    fill_d  = fill_q;
    case (state_q)
      scflp_pkg::ST_IDLE: begin
        if (accept) begin
          rsp_d.rounded_size    = rounded;
          rsp_d.granted_address = '0;
          state_d               = scflp_pkg::ST_RESP;
          if (!is_free) begin
            if (can_pop) begin
              fill_d[cls_sel] = pos;
              rsp_d.outcome   = scflp_pkg::OC_POOL;
              state_d         = scflp_pkg::ST_READ;
            end else begin
              total_d       = total_q + $signed({32'd0, rounded});
              rsp_d.outcome = scflp_pkg::OC_BACKING;
            end
          end else begin
            if (can_push) begin
              fill_d[cls_sel] = fill_cur + 1'b1;
              rsp_d.outcome   = scflp_pkg::OC_KEPT;
            end else begin
              total_d       = total_q - $signed({32'd0, rounded});
              rsp_d.outcome = scflp_pkg::OC_RELEASED;
            end
          end
          rsp_d.backing_bytes = total_d;
        end
      end
      scflp_pkg::ST_READ: begin
        rsp_d.granted_address = addr_out_wide[scflp_pkg::OADDR_W-1:0];
        state_d               = scflp_pkg::ST_RESP;
      end
      scflp_pkg::ST_RESP: begin
        if (out_ready_i) begin
          state_d = scflp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = scflp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scflp_pkg::ST_IDLE;
      limit_q <= scflp_pkg::LIMIT_RESET;
      total_q <= '0;
      for (int i = 0; i < scflp_pkg::NUM_CLASSES; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      fill_q  <= fill_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

endmodule

### hw/rtl/scflp_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module scflp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/scflp_checker.sv
// Port-level checker for the size-class free-list pool, bound to the top level.
// Depends on scflp_pkg and size_class_free_list_pool_core_assert.svh.
`include "size_class_free_list_pool_core_assert.svh"

module scflp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input scflp_pkg::rsp_t               out_rsp_o
);

  // a stalled response stays up
  `SCFLP_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "response dropped")

  // one request in flight: no new request while a response waits
  `SCFLP_ASSERT(a_one_in_flight, out_valid_o |-> !in_ready_o, "request taken with response pending")

  // an accepted request never responds in the same cycle
  `SCFLP_ASSERT(a_accept_gap, in_valid_i && in_ready_o |=> !in_ready_o, "no response phase")

  // only a pool allocation hands out an address
  `SCFLP_ASSERT(a_grant_zero,
      out_valid_o && (out_rsp_o.outcome != scflp_pkg::OC_POOL) |-> out_rsp_o.granted_address == '0,
      "address granted without pool hit")

  // nothing is shown while reset holds
  `SCFLP_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "response during reset")

endmodule

bind size_class_free_list_pool_core scflp_checker u_scflp_checker (.*);
